FILE: rtl/core/qte_pkg.sv
`timescale 1ns / 1ps

package qte_pkg;

  localparam int QUAT_BITS_DEF  = 16;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int TURN_BITS      = 32;
  localparam int CORDIC_STEPS   = 30;
  localparam int SQRT_BITS      = 31;
  localparam int RAD_BITS       = 62;
  localparam int FRONT_LAT      = 6;

  localparam logic [TURN_BITS-1:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [TURN_BITS-1:0] TURN_HALF    = 32'h8000_0000;

  // arctangent of 2^-i, full turn = 2^32
  function automatic logic [TURN_BITS-1:0] atan_entry(input int unsigned i);
    logic [TURN_BITS-1:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // add half an output lsb ahead of truncation
  function automatic logic [TURN_BITS-1:0] round_turn(input logic [TURN_BITS-1:0] a,
                                                     input int sh);
    logic [TURN_BITS-1:0] r;
    if (sh == 0) begin
      r = a;
    end else begin
      r = a + (32'd1 << (sh - 1));
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/qte_in_if.sv
`timescale 1ns / 1ps

interface qte_in_if #(
  parameter int QUAT_BITS = qte_pkg::QUAT_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [QUAT_BITS-1:0] quat_w;
  logic signed [QUAT_BITS-1:0] quat_x;
  logic signed [QUAT_BITS-1:0] quat_y;
  logic signed [QUAT_BITS-1:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

FILE: rtl/core/qte_out_if.sv
`timescale 1ns / 1ps

interface qte_out_if #(
  parameter int ANGLE_BITS = qte_pkg::ANGLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] yaw_angle;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] roll_angle;
  logic                         pitch_clipped;

  modport source (output valid, yaw_angle, pitch_angle, roll_angle, pitch_clipped,
                  input ready);
  modport sink (input valid, yaw_angle, pitch_angle, roll_angle, pitch_clipped,
                output ready);
endinterface

FILE: rtl/core/qte_front.sv
`timescale 1ns / 1ps

module qte_front #(
  parameter int QUAT_BITS = qte_pkg::QUAT_BITS_DEF,
  localparam int W  = (QUAT_BITS > 30) ? 30 : QUAT_BITS,
  localparam int SW = 2 * W + 2
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [QUAT_BITS-1:0]       quat_w,
  input  logic signed [QUAT_BITS-1:0]       quat_x,
  input  logic signed [QUAT_BITS-1:0]       quat_y,
  input  logic signed [QUAT_BITS-1:0]       quat_z,
  output logic [qte_pkg::RAD_BITS-1:0]      rad,
  output logic signed [qte_pkg::TURN_BITS-1:0] pitch_y,
  output logic                              clip,
  output logic                              clip_neg,
  output logic signed [SW-1:0]              yaw_n,
  output logic signed [SW-1:0]              yaw_d,
  output logic signed [SW-1:0]              roll_n,
  output logic signed [SW-1:0]              roll_d
);

  localparam int E   = 2 * (W - 1);
  localparam int RSH = (E >= 30) ? E - 30 : 0;
  localparam int LSH = (E >= 30) ? 0 : 30 - E;
  localparam int XW  = SW + LSH;
  localparam logic signed [SW-1:0] UNIT = SW'(1) <<< E;
  localparam logic [XW-1:0] S30_MAX = XW'(1) << 30;
  localparam logic [qte_pkg::RAD_BITS-1:0] RAD_ONE = qte_pkg::RAD_BITS'(1) << 60;

  // stage 1: working precision
  logic signed [W-1:0] w1, x1, y1, z1;
  // stage 2: products
  logic signed [2*W-1:0] p_xy, p_wz, p_yy, p_zz, p_wx, p_yz, p_xx, p_wy, p_zx;
  // stage 3: sums
  logic signed [SW-1:0] yn3, yd3, rn3, rd3, sarg3;
  // stage 4: pitch argument at 30 fraction bits
  logic signed [SW-1:0] yn4, yd4, rn4, rd4;
  logic [qte_pkg::SQRT_BITS-1:0] s30_4;
  logic signed [qte_pkg::TURN_BITS-1:0] py4;
  logic clip4, neg4;
  // stage 5: square
  logic signed [SW-1:0] yn5, yd5, rn5, rd5;
  logic [qte_pkg::RAD_BITS-1:0] sq5;
  logic signed [qte_pkg::TURN_BITS-1:0] py5;
  logic clip5, neg5;

  logic [SW-1:0] smag;
  logic [XW-1:0] sx;
  logic [qte_pkg::SQRT_BITS-1:0] s30;
  logic signed [qte_pkg::TURN_BITS-1:0] s30_s;

  always_comb begin
    smag  = sarg3[SW-1] ? SW'(-sarg3) : SW'(sarg3);
    sx    = (XW'(smag) >> RSH) << LSH;
    s30   = (sx > S30_MAX) ? qte_pkg::SQRT_BITS'(S30_MAX) : sx[qte_pkg::SQRT_BITS-1:0];
    s30_s = {1'b0, s30};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1 <= quat_w[QUAT_BITS-1 -: W];
      x1 <= quat_x[QUAT_BITS-1 -: W];
      y1 <= quat_y[QUAT_BITS-1 -: W];
      z1 <= quat_z[QUAT_BITS-1 -: W];

      p_xy <= x1 * y1;
      p_wz <= w1 * z1;
      p_yy <= y1 * y1;
      p_zz <= z1 * z1;
      p_wx <= w1 * x1;
      p_yz <= y1 * z1;
      p_xx <= x1 * x1;
      p_wy <= w1 * y1;
      p_zx <= z1 * x1;

      yn3   <= (SW'(p_xy) + SW'(p_wz)) <<< 1;
      yd3   <= UNIT - ((SW'(p_yy) + SW'(p_zz)) <<< 1);
      rn3   <= (SW'(p_wx) + SW'(p_yz)) <<< 1;
      rd3   <= UNIT - ((SW'(p_xx) + SW'(p_yy)) <<< 1);
      sarg3 <= (SW'(p_wy) - SW'(p_zx)) <<< 1;

      yn4   <= yn3;
      yd4   <= yd3;
      rn4   <= rn3;
      rd4   <= rd3;
      clip4 <= (sarg3 > UNIT) || (sarg3 < -UNIT);
      neg4  <= sarg3[SW-1];
      s30_4 <= s30;
      py4   <= sarg3[SW-1] ? -s30_s : s30_s;

      yn5   <= yn4;
      yd5   <= yd4;
      rn5   <= rn4;
      rd5   <= rd4;
      clip5 <= clip4;
      neg5  <= neg4;
      py5   <= py4;
      sq5   <= s30_4 * s30_4;

      yaw_n    <= yn5;
      yaw_d    <= yd5;
      roll_n   <= rn5;
      roll_d   <= rd5;
      clip     <= clip5;
      clip_neg <= neg5;
      pitch_y  <= py5;
      rad      <= RAD_ONE - sq5;
    end
  end

endmodule

FILE: rtl/core/qte_sqrt.sv
`timescale 1ns / 1ps

module qte_sqrt #(
  parameter int TW = 8
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [qte_pkg::RAD_BITS-1:0]      rad,
  input  logic [TW-1:0]                     tag_in,
  output logic [qte_pkg::SQRT_BITS-1:0]     root,
  output logic [TW-1:0]                     tag_out
);

  localparam int NB = qte_pkg::SQRT_BITS;
  localparam int RB = qte_pkg::RAD_BITS;

  logic [RB-1:0] rem_q  [0:NB-2];
  logic [NB-1:0] root_q [0:NB-1];
  logic [TW-1:0] tag_q  [0:NB-1];

  // one result bit per stage, msb first
  for (genvar k = 0; k < NB; k++) begin : g_stage
    localparam int B = NB - 1 - k;
    logic [RB-1:0] rem_c;
    logic [NB-1:0] root_c;
    logic [TW-1:0] tag_c;
    logic [RB-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_c  = rad;
      assign root_c = '0;
      assign tag_c  = tag_in;
    end else begin : g_next
      assign rem_c  = rem_q[k-1];
      assign root_c = root_q[k-1];
      assign tag_c  = tag_q[k-1];
    end

    assign trial = (RB'(root_c) << (B + 1)) | (RB'(1) << (2 * B));
    assign take  = rem_c >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k] <= take ? (root_c | (NB'(1) << B)) : root_c;
        tag_q[k]  <= tag_c;
      end
    end

    if (k < NB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= take ? rem_c - trial : rem_c;
        end
      end
    end
  end

  assign root    = root_q[NB-1];
  assign tag_out = tag_q[NB-1];

endmodule

FILE: rtl/core/qte_atan2.sv
`timescale 1ns / 1ps

module qte_atan2 #(
  parameter int AW = 34
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [AW-1:0]              yv,
  input  logic signed [AW-1:0]              xv,
  output logic [qte_pkg::TURN_BITS-1:0]     angle
);

  localparam int NS = $clog2(AW);
  localparam int NC = qte_pkg::CORDIC_STEPS;
  localparam int CW = 35;
  localparam int ZW = 33;

  logic [AW-1:0] nax [0:NS];
  logic [AW-1:0] nay [0:NS];
  logic          nxn [0:NS];
  logic          nyn [0:NS];

  always_ff @(posedge clk) begin
    if (en) begin
      nax[0] <= xv[AW-1] ? AW'(-xv) : AW'(xv);
      nay[0] <= yv[AW-1] ? AW'(-yv) : AW'(yv);
      nxn[0] <= xv[AW-1];
      nyn[0] <= yv[AW-1];
    end
  end

  // leading-zero shift, largest step first; top 32 bits are the scaled pair
  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int S = 1 << (NS - 1 - j);
    logic [AW-1:0] m;
    logic          sh;
    assign m  = nax[j] | nay[j];
    assign sh = (m[AW-1 -: S] == '0);
    always_ff @(posedge clk) begin
      if (en) begin
        nax[j+1] <= sh ? (nax[j] << S) : nax[j];
        nay[j+1] <= sh ? (nay[j] << S) : nay[j];
        nxn[j+1] <= nxn[j];
        nyn[j+1] <= nyn[j];
      end
    end
  end

  logic [31:0] ax32, ay32;
  assign ax32 = nax[NS][AW-1 -: 32];
  assign ay32 = nay[NS][AW-1 -: 32];

  logic signed [CW-1:0] cx_q [0:NC-1];
  logic signed [CW-1:0] cy_q [0:NC-1];
  logic signed [ZW-1:0] z_q  [0:NC-1];
  logic                 yz_q [0:NC-1];
  logic                 xz_q [0:NC-1];
  logic                 xn_q [0:NC-1];
  logic                 yn_q [0:NC-1];

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    logic signed [CW-1:0] cx, cy;
    logic signed [ZW-1:0] z, t;
    logic                 yz, xz, xn, yn, up;

    if (i == 0) begin : g_first
      assign cx = {3'b000, ax32};
      assign cy = {3'b000, ay32};
      assign z  = '0;
      assign yz = (ay32 == '0);
      assign xz = (ax32 == '0);
      assign xn = nxn[NS];
      assign yn = nyn[NS];
    end else begin : g_next
      assign cx = cx_q[i-1];
      assign cy = cy_q[i-1];
      assign z  = z_q[i-1];
      assign yz = yz_q[i-1];
      assign xz = xz_q[i-1];
      assign xn = xn_q[i-1];
      assign yn = yn_q[i-1];
    end

    assign t  = ZW'(qte_pkg::atan_entry(i));
    assign up = !cy[CW-1] && (cy != '0);

    always_ff @(posedge clk) begin
      if (en) begin
        cx_q[i] <= up ? cx + (cy >>> i) : cx - (cy >>> i);
        cy_q[i] <= up ? cy - (cx >>> i) : cy + (cx >>> i);
        z_q[i]  <= up ? z + t : z - t;
        yz_q[i] <= yz;
        xz_q[i] <= xz;
        xn_q[i] <= xn;
        yn_q[i] <= yn;
      end
    end
  end

  // cx/cy of the last step are not needed past this point
  logic signed [ZW-1:0] zf;
  logic [31:0]          a0, a1, a2;

  always_comb begin
    if (yz_q[NC-1]) begin
      zf = '0;
    end else if (xz_q[NC-1]) begin
      zf = ZW'(qte_pkg::TURN_QUARTER);
    end else if (z_q[NC-1] < 0) begin
      zf = '0;
    end else if (z_q[NC-1] > ZW'(qte_pkg::TURN_QUARTER)) begin
      zf = ZW'(qte_pkg::TURN_QUARTER);
    end else begin
      zf = z_q[NC-1];
    end
    a0 = zf[31:0];
    a1 = xn_q[NC-1] ? qte_pkg::TURN_HALF - a0 : a0;
    a2 = yn_q[NC-1] ? -a1 : a1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= a2;
    end
  end

  logic unused_ok;
  assign unused_ok = ^{cx_q[NC-1], cy_q[NC-1]};

endmodule

FILE: rtl/core/quaternion_to_euler.sv
`timescale 1ns / 1ps

// ZYX Euler angles (yaw, pitch, roll) from a signed fixed-point quaternion, one
// quaternion accepted every clock cycle unless the skid buffer is full. Results
// are binary angles in which 2^(ANGLE_BITS-1) stands for pi; pitch saturates to
// a quarter turn and sets pitch_clipped when the asin argument leaves the unit
// range. Data passes the front end at working precision W = min(QUAT_BITS, 30),
// then the 31-stage square root feeding the 30-stage CORDIC. Inputs stay ready
// until the one-entry skid buffer behind the output register is full.
module quaternion_to_euler #(
  parameter int QUAT_BITS  = qte_pkg::QUAT_BITS_DEF,
  parameter int ANGLE_BITS = qte_pkg::ANGLE_BITS_DEF
) (
  input logic     clk,
  input logic     rst,
  qte_in_if.sink  quat,
  qte_out_if.source euler
);

  localparam int W   = (QUAT_BITS > 30) ? 30 : QUAT_BITS;
  localparam int SW  = 2 * W + 2;
  localparam int AW  = (SW > 32) ? SW : 32;
  localparam int NS  = $clog2(AW);
  localparam int LA  = NS + qte_pkg::CORDIC_STEPS + 2;
  localparam int L   = qte_pkg::FRONT_LAT + qte_pkg::SQRT_BITS + LA + 1;
  localparam int TB  = qte_pkg::TURN_BITS;
  localparam int TW  = 4 * SW + TB + 2;
  localparam int SH  = TB - ANGLE_BITS;
  localparam logic signed [ANGLE_BITS-1:0] QUARTER_A = ANGLE_BITS'(1) <<< (ANGLE_BITS - 2);

  logic en;
  logic skid_valid;

  assign en         = !skid_valid;
  assign quat.ready = en;

  // valid bits ride along with the data
  logic [L-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], quat.valid};
    end
  end

  logic [qte_pkg::RAD_BITS-1:0] rad;
  logic signed [TB-1:0] pitch_y;
  logic clip, clip_neg;
  logic signed [SW-1:0] yaw_n, yaw_d, roll_n, roll_d;

  qte_front #(.QUAT_BITS(QUAT_BITS)) u_front (
    .clk      (clk),
    .en       (en),
    .quat_w   (quat.quat_w),
    .quat_x   (quat.quat_x),
    .quat_y   (quat.quat_y),
    .quat_z   (quat.quat_z),
    .rad      (rad),
    .pitch_y  (pitch_y),
    .clip     (clip),
    .clip_neg (clip_neg),
    .yaw_n    (yaw_n),
    .yaw_d    (yaw_d),
    .roll_n   (roll_n),
    .roll_d   (roll_d)
  );

  logic [qte_pkg::SQRT_BITS-1:0] root;
  logic [TW-1:0] tag_o;

  qte_sqrt #(.TW(TW)) u_sqrt (
    .clk     (clk),
    .en      (en),
    .rad     (rad),
    .tag_in  ({yaw_n, yaw_d, roll_n, roll_d, pitch_y, clip, clip_neg}),
    .root    (root),
    .tag_out (tag_o)
  );

  logic signed [SW-1:0] s_yn, s_yd, s_rn, s_rd;
  logic signed [TB-1:0] s_py;
  logic s_clip, s_neg;
  assign {s_yn, s_yd, s_rn, s_rd, s_py, s_clip, s_neg} = tag_o;

  logic [TB-1:0] yaw_a, pitch_a, roll_a;

  qte_atan2 #(.AW(AW)) u_yaw (
    .clk (clk), .en (en), .yv (AW'(s_yn)), .xv (AW'(s_yd)), .angle (yaw_a)
  );

  qte_atan2 #(.AW(AW)) u_pitch (
    .clk (clk), .en (en), .yv (AW'(s_py)),
    .xv (AW'(signed'({1'b0, root}))), .angle (pitch_a)
  );

  qte_atan2 #(.AW(AW)) u_roll (
    .clk (clk), .en (en), .yv (AW'(s_rn)), .xv (AW'(s_rd)), .angle (roll_a)
  );

  logic [LA-1:0] clip_d, neg_d;
  always_ff @(posedge clk) begin
    if (en) begin
      clip_d <= {clip_d[LA-2:0], s_clip};
      neg_d  <= {neg_d[LA-2:0], s_neg};
    end
  end

  logic [TB-1:0] pitch_sel, yaw_r32, pitch_r32, roll_r32;
  always_comb begin
    if (clip_d[LA-1]) begin
      pitch_sel = neg_d[LA-1] ? -qte_pkg::TURN_QUARTER : qte_pkg::TURN_QUARTER;
    end else begin
      pitch_sel = pitch_a;
    end
    yaw_r32   = qte_pkg::round_turn(yaw_a, SH);
    pitch_r32 = qte_pkg::round_turn(pitch_sel, SH);
    roll_r32  = qte_pkg::round_turn(roll_a, SH);
  end

  logic signed [ANGLE_BITS-1:0] yaw_r, pitch_r, roll_r;
  logic clip_r;
  always_ff @(posedge clk) begin
    if (en) begin
      yaw_r   <= yaw_r32[TB-1:SH];
      pitch_r <= pitch_r32[TB-1:SH];
      roll_r  <= roll_r32[TB-1:SH];
      clip_r  <= clip_d[LA-1];
    end
  end

  // output register plus one-entry skid
  logic out_valid;
  logic signed [ANGLE_BITS-1:0] o_yaw, o_pitch, o_roll, k_yaw, k_pitch, k_roll;
  logic o_clip, k_clip;
  logic leaving, out_free;

  assign leaving  = en && vld[L-1];
  assign out_free = !out_valid || euler.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || leaving;
      skid_valid <= 1'b0;
    end else if (leaving) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        o_yaw   <= k_yaw;
        o_pitch <= k_pitch;
        o_roll  <= k_roll;
        o_clip  <= k_clip;
      end else begin
        o_yaw   <= yaw_r;
        o_pitch <= pitch_r;
        o_roll  <= roll_r;
        o_clip  <= clip_r;
      end
    end else if (leaving) begin
      k_yaw   <= yaw_r;
      k_pitch <= pitch_r;
      k_roll  <= roll_r;
      k_clip  <= clip_r;
    end
  end

  assign euler.valid         = out_valid;
  assign euler.yaw_angle     = o_yaw;
  assign euler.pitch_angle   = o_pitch;
  assign euler.roll_angle    = o_roll;
  assign euler.pitch_clipped = o_clip;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a transaction while output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !euler.ready))
    else $error("skid filled without a stalled output");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (o_pitch <= QUARTER_A) && (o_pitch >= -QUARTER_A))
    else $error("pitch outside quarter turn");

  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && o_clip) |-> (o_pitch == QUARTER_A) || (o_pitch == -QUARTER_A))
    else $error("clipped pitch not saturated");

endmodule

FILE: tb/tb_quaternion_to_euler.sv
`timescale 1ns / 1ps

module tb_quaternion_to_euler;

  localparam int QB = qte_pkg::QUAT_BITS_DEF;
  localparam int AB = qte_pkg::ANGLE_BITS_DEF;
  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic signed [QB-1:0] w;
    logic signed [QB-1:0] x;
    logic signed [QB-1:0] y;
    logic signed [QB-1:0] z;
    bit                   hold;
  } quat_item_t;

  typedef struct {
    logic [AB-1:0] yaw;
    logic [AB-1:0] pitch;
    logic [AB-1:0] roll;
    logic          clip;
  } euler_t;

  localparam longint ATAN_LUT [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  qte_in_if  #(.QUAT_BITS(QB))  quat_bus ();
  qte_out_if #(.ANGLE_BITS(AB)) euler_bus ();

  quaternion_to_euler #(.QUAT_BITS(QB), .ANGLE_BITS(AB)) dut (
    .clk   (clk),
    .rst   (rst),
    .quat  (quat_bus),
    .euler (euler_bus)
  );

  always #4 clk = ~clk;

  quat_item_t  quat_queue[$];
  euler_t      angle_queue[$];
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned quats_sent = 0;
  int unsigned angles_seen = 0;
  int unsigned clipped_seen = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  bit          quat_taken = 1'b0;

  function automatic logic [63:0] mag(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // vectoring cordic, full turn = 2^32
  function automatic logic [31:0] turn_atan2(input longint yv, input longint xv);
    logic [63:0] ax, ay, m;
    longint cx, cy, ang, dx, dy;
    logic [31:0] a;
    ax = mag(xv);
    ay = mag(yv);
    m = ax | ay;
    if (m == 0) return 32'd0;
    while (m >= 64'h1_0000_0000) begin
      ax = ax >> 1; ay = ay >> 1; m = m >> 1;
    end
    while (m < 64'h8000_0000) begin
      ax = ax << 1; ay = ay << 1; m = m << 1;
    end
    cx = longint'(ax);
    cy = longint'(ay);
    ang = 0;
    if (ay == 0) begin
      ang = 0;
    end else if (ax == 0) begin
      ang = 64'h4000_0000;
    end else begin
      for (int i = 0; i < 30; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy > 0) begin
          cx = cx + dx; cy = cy - dy; ang = ang + ATAN_LUT[i];
        end else begin
          cx = cx - dx; cy = cy + dy; ang = ang - ATAN_LUT[i];
        end
      end
    end
    if (ang < 0) ang = 0;
    if (ang > 64'h4000_0000) ang = 64'h4000_0000;
    a = ang[31:0];
    if (xv < 0) a = 32'h8000_0000 - a;
    if (yv < 0) a = 32'd0 - a;
    return a;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] r);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > r) b = b >> 2;
    while (b != 0) begin
      if (r >= res + b) begin
        r = r - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [AB-1:0] to_bam(input logic [31:0] a);
    logic [32:0] t;
    t = {1'b0, a} + 33'h8000;
    return t[31:16];
  endfunction

  function automatic euler_t zyx_angles(input quat_item_t q);
    longint w, x, y, z, unit, yn, yd, rn, rd, sarg;
    logic [63:0] s30, c;
    logic [31:0] p;
    euler_t r;
    w = q.w; x = q.x; y = q.y; z = q.z;
    unit = 64'd1 << 30;
    yn = 2 * (x * y + w * z);
    yd = unit - 2 * (y * y + z * z);
    rn = 2 * (w * x + y * z);
    rd = unit - 2 * (x * x + y * y);
    sarg = 2 * (w * y - z * x);
    r.clip = 1'b0;
    if (sarg > unit) begin
      p = 32'h4000_0000;
      r.clip = 1'b1;
    end else if (sarg < -unit) begin
      p = 32'hC000_0000;
      r.clip = 1'b1;
    end else begin
      s30 = mag(sarg);
      c = int_sqrt((64'd1 << 60) - s30 * s30);
      p = turn_atan2(longint'(s30), longint'(c));
      if (sarg < 0) p = 32'd0 - p;
    end
    r.yaw = to_bam(turn_atan2(yn, yd));
    r.pitch = to_bam(p);
    r.roll = to_bam(turn_atan2(rn, rd));
    return r;
  endfunction

  function automatic quat_item_t mk_quat(input int w, input int x, input int y, input int z);
    quat_item_t q;
    q.w = w[QB-1:0]; q.x = x[QB-1:0]; q.y = y[QB-1:0]; q.z = z[QB-1:0];
    q.hold = 1'b0;
    return q;
  endfunction

  function automatic quat_item_t hold_marker();
    quat_item_t q;
    q = mk_quat(0, 0, 0, 0);
    q.hold = 1'b1;
    return q;
  endfunction

  // random unit quaternion, optionally pushed toward gimbal lock
  function automatic quat_item_t unit_quat(input bit near_lock);
    real c [4];
    real n;
    c[0] = real'($urandom_range(20000)) - 10000.0;
    c[1] = real'($urandom_range(20000)) - 10000.0;
    c[2] = real'($urandom_range(20000)) - 10000.0;
    c[3] = real'($urandom_range(20000)) - 10000.0;
    if (near_lock) begin
      c[2] = c[0] + real'($urandom_range(200)) - 100.0;
      c[3] = -c[1] + real'($urandom_range(200)) - 100.0;
    end
    n = $sqrt(c[0]*c[0] + c[1]*c[1] + c[2]*c[2] + c[3]*c[3]);
    if (n < 1.0) n = 1.0;
    return mk_quat(int'(c[0] / n * 32767.0), int'(c[1] / n * 32767.0),
                   int'(c[2] / n * 32767.0), int'(c[3] / n * 32767.0));
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("quaternion_to_euler test failed");
      $finish;
    end
  end

  // input side: record expectation for each accepted transaction
  always @(posedge clk) begin
    quat_item_t q;
    quat_taken <= 1'b0;
    if (!rst && quat_bus.valid && quat_bus.ready) begin
      q = mk_quat(quat_bus.quat_w, quat_bus.quat_x, quat_bus.quat_y, quat_bus.quat_z);
      angle_queue.push_back(zyx_angles(q));
      quats_sent <= quats_sent + 1;
      quat_taken <= 1'b1;
    end
  end

  // output side: compare against oldest expectation
  always @(posedge clk) begin
    euler_t exp_a;
    if (!rst && euler_bus.valid && euler_bus.ready) begin
      angles_seen <= angles_seen + 1;
      if (euler_bus.pitch_clipped) clipped_seen <= clipped_seen + 1;
      if (angle_queue.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result yaw=%0d pitch=%0d roll=%0d clip=%0b",
                   euler_bus.yaw_angle, euler_bus.pitch_angle,
                   euler_bus.roll_angle, euler_bus.pitch_clipped);
      end else begin
        exp_a = angle_queue.pop_front();
        if (exp_a.yaw !== euler_bus.yaw_angle || exp_a.pitch !== euler_bus.pitch_angle ||
            exp_a.roll !== euler_bus.roll_angle || exp_a.clip !== euler_bus.pitch_clipped) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp y/p/r/c %0d %0d %0d %0b, got %0d %0d %0d %0b",
                     $signed(exp_a.yaw), $signed(exp_a.pitch), $signed(exp_a.roll),
                     exp_a.clip, euler_bus.yaw_angle, euler_bus.pitch_angle,
                     euler_bus.roll_angle, euler_bus.pitch_clipped);
        end
      end
    end
  end

  // driver: bursts with gaps, hold markers wait for a full drain
  always @(negedge clk) begin
    quat_item_t q;
    if (rst) begin
      quat_bus.valid <= 1'b0;
    end else if (!quat_bus.valid || quat_taken) begin
      if (quat_queue.size() == 0) begin
        quat_bus.valid <= 1'b0;
      end else if (quat_queue[0].hold) begin
        quat_bus.valid <= 1'b0;
        if (angle_queue.size() == 0) void'(quat_queue.pop_front());
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        quat_bus.valid <= 1'b0;
      end else begin
        q = quat_queue.pop_front();
        quat_bus.quat_w <= q.w;
        quat_bus.quat_x <= q.x;
        quat_bus.quat_y <= q.y;
        quat_bus.quat_z <= q.z;
        quat_bus.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver stall pattern, mode redrawn whenever the low eight bits of the cycle counter are zero
  always @(negedge clk) begin
    if (rst) begin
      euler_bus.ready <= 1'b0;
    end else begin
      if (cycles[7:0] == 8'd0) stall_mode <= $urandom_range(3);
      case (stall_mode)
        0: euler_bus.ready <= 1'b1;
        1: euler_bus.ready <= ($urandom_range(1) == 1);
        2: euler_bus.ready <= ((cycles % 7) > 2);
        default: euler_bus.ready <= ($urandom_range(15) == 0);
      endcase
    end
  end

  initial begin
    int kind;
    quat_bus.valid = 1'b0;
    quat_bus.quat_w = '0;
    quat_bus.quat_x = '0;
    quat_bus.quat_y = '0;
    quat_bus.quat_z = '0;
    euler_bus.ready = 1'b0;

    quat_queue.push_back(mk_quat(0, 0, 0, 0));
    quat_queue.push_back(mk_quat(32767, 0, 0, 0));
    quat_queue.push_back(mk_quat(-32768, 0, 0, 0));
    quat_queue.push_back(mk_quat(0, 32767, 0, 0));        // roll at pi
    quat_queue.push_back(mk_quat(0, 0, 0, 32767));        // yaw at pi
    quat_queue.push_back(mk_quat(0, 0, 32767, 0));
    quat_queue.push_back(mk_quat(32767, 32767, 32767, 32767));
    quat_queue.push_back(mk_quat(-32768, -32768, -32768, -32768));
    quat_queue.push_back(mk_quat(32767, -32768, 32767, -32768));
    quat_queue.push_back(mk_quat(16384, 16384, 16384, -16384));  // asin arg exactly +1
    quat_queue.push_back(mk_quat(16384, 16384, -16384, 16384));  // asin arg exactly -1
    quat_queue.push_back(mk_quat(32767, 0, 32767, 0));           // clipped high
    quat_queue.push_back(mk_quat(32767, 0, -32768, 0));          // clipped low
    quat_queue.push_back(mk_quat(23170, 0, 23170, 0));
    quat_queue.push_back(mk_quat(23170, 23170, 0, 0));
    quat_queue.push_back(mk_quat(23170, 0, 0, -23170));
    quat_queue.push_back(mk_quat(1, -1, 1, -1));
    quat_queue.push_back(mk_quat(0, 0, 0, -32768));
    quat_queue.push_back(hold_marker());

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(9);
      if (kind < 5)
        quat_queue.push_back(unit_quat(1'b0));
      else if (kind < 7)
        quat_queue.push_back(unit_quat(1'b1));
      else
        quat_queue.push_back(mk_quat($urandom, $urandom, $urandom, $urandom));
      if (i % 500 == 499) quat_queue.push_back(hold_marker());
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (quat_queue.size() != 0 || quat_bus.valid) @(posedge clk);
    while (angle_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d quaternions (directed extremes, unit, near gimbal lock, raw bits)",
             quats_sent);
    $display("checked %0d results, %0d with pitch clipped, %0d mismatches",
             angles_seen, clipped_seen, mismatches);
    if (mismatches == 0 && angle_queue.size() == 0) begin
      $display("quaternion_to_euler test passed");
    end else begin
      $display("quaternion_to_euler test failed");
    end
    $finish;
  end

endmodule
